@@ hw/rtl/llps_pkg.sv @@
package llps_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned IVL_W = 20;
  localparam int unsigned WIN_W = 22;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned BO_W = 14;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned OP_W = 3;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned MIN_INTERVAL_MS = 300;
  localparam int unsigned TIMEOUT_EXTRA_MS = 500;
  localparam int unsigned BACKOFF_BASE_MS = 200;
  localparam int unsigned BACKOFF_MAX_MS = 8000;
  localparam int unsigned BACKOFF_SHIFT_CAP = 6;
  localparam int unsigned STREAK_MAX = 255;
  localparam int unsigned INTERVAL_RESET = 1000;
  localparam int unsigned LIMIT_RESET = 2;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // input event codes
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPLY    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACTIVITY = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ENABLE   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESET    = 3'd4;

  // decoded operations handed to the back end
  localparam logic [OP_W-1:0] OP_IDLE   = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
  localparam logic [OP_W-1:0] OP_HEARD  = 3'd2;
  localparam logic [OP_W-1:0] OP_ENABLE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [KIND_W-1:0] REQ_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] REQ_PROBE = 2'd1;
  localparam logic [KIND_W-1:0] REQ_PULL  = 2'd2;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_TO_LIMIT = 2'd1;
  localparam logic [1:0] REG_ST_LIMIT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now;
    logic              accept;
    logic              flag;    // reply online / activity / enable value
  } cmd_t;

  typedef struct packed {
    logic [IVL_W-1:0] interval;
    logic [WIN_W-1:0] reply_window;
    logic [WIN_W-1:0] stale_window;
    logic [CNT_W-1:0] to_limit;
    logic [CNT_W-1:0] st_limit;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              sent;
    logic [TIME_W-1:0] id;
    logic              off_to;
    logic              off_st;
    logic              rec;
    logic              online;
  } res_t;

  function automatic logic [WIN_W-1:0] reply_window_of(input logic [IVL_W-1:0] iv);
    return {1'b0, iv, 1'b0} + WIN_W'(TIMEOUT_EXTRA_MS);
  endfunction

  function automatic logic [WIN_W-1:0] stale_window_of(input logic [IVL_W-1:0] iv);
    return {1'b0, iv, 1'b0} + {2'b00, iv} + WIN_W'(TIMEOUT_EXTRA_MS);
  endfunction

  // wrapping "a is at or after b"
  function automatic logic time_reached(input logic [TIME_W-1:0] a,
                                        input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return !d[TIME_W-1];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == CNT_W'(STREAK_MAX)) ? x : x + 1'b1;
  endfunction

  function automatic logic [BO_W-1:0] backoff_ms(input logic [CNT_W-1:0] cnt);
    logic [2:0]  n;
    logic [19:0] b;
    n = (cnt > CNT_W'(BACKOFF_SHIFT_CAP)) ? 3'(BACKOFF_SHIFT_CAP) : cnt[2:0];
    b = 20'(BACKOFF_BASE_MS) << n;
    return (b > 20'(BACKOFF_MAX_MS)) ? BO_W'(BACKOFF_MAX_MS) : b[BO_W-1:0];
  endfunction

endpackage

@@ hw/rtl/llps_front.sv @@
module llps_front
  import llps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              poll_permit,
  input  logic              tx_accept,
  input  logic              reply_online,
  input  logic              enable_flag,
  output logic              push,
  output cmd_t              push_cmd,
  input  logic              q_full
);

  logic fr_valid;
  cmd_t fr_cmd;
  cmd_t dec;
  logic load;

  always_comb begin
    dec.op     = OP_IDLE;
    dec.now    = now_ms;
    dec.accept = tx_accept;
    dec.flag   = 1'b0;
    case (func)
      FUNC_TICK: begin
        dec.op = poll_permit ? OP_TICK : OP_IDLE;
      end
      FUNC_REPLY: begin
        dec.op   = OP_HEARD;
        dec.flag = reply_online;
      end
      FUNC_ACTIVITY: begin
        dec.op   = OP_HEARD;
        dec.flag = 1'b1;
      end
      FUNC_ENABLE: begin
        dec.op   = OP_ENABLE;
        dec.flag = enable_flag;
      end
      FUNC_RESET: begin
        dec.op = OP_CLEAR;
      end
      default: begin
        dec.op = OP_IDLE;
      end
    endcase
  end

  assign push     = fr_valid && !q_full;
  assign in_stall = fr_valid && q_full;
  assign load     = in_valid && !in_stall;
  assign push_cmd = fr_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (load) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_cmd <= dec;
    end
  end

endmodule

@@ hw/rtl/llps_queue.sv @@
module llps_queue
  import llps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/llps_back.sv @@
module llps_back
  import llps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic head_valid,
  input  cmd_t head_cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output res_t res
);

  logic              poll_enabled;
  logic              link_online;
  logic              awaiting_reply;
  logic [TIME_W-1:0] next_probe_time;
  logic [TIME_W-1:0] next_pull_time;
  logic [TIME_W-1:0] last_reply_time;
  logic [TIME_W-1:0] last_probe_time;
  logic [TIME_W-1:0] last_activity_time;
  logic [CNT_W-1:0]  send_fail_count;
  logic [TIME_W-1:0] backoff_end_time;
  logic [CNT_W-1:0]  timeout_streak;
  logic [CNT_W-1:0]  stale_streak;
  logic [TIME_W-1:0] next_request_id;

  logic              poll_enabled_next;
  logic              link_online_next;
  logic              awaiting_reply_next;
  logic [TIME_W-1:0] next_probe_time_next;
  logic [TIME_W-1:0] next_pull_time_next;
  logic [TIME_W-1:0] last_reply_time_next;
  logic [TIME_W-1:0] last_probe_time_next;
  logic [TIME_W-1:0] last_activity_time_next;
  logic [CNT_W-1:0]  send_fail_count_next;
  logic [TIME_W-1:0] backoff_end_time_next;
  logic [CNT_W-1:0]  timeout_streak_next;
  logic [CNT_W-1:0]  stale_streak_next;
  logic [TIME_W-1:0] next_request_id_next;
  res_t              res_next;

  logic              in_backoff;
  logic              probe_due;
  logic              pull_due;
  logic [CNT_W-1:0]  fail_inc;
  logic [TIME_W-1:0] now_plus_bo;
  logic [TIME_W-1:0] now_plus_ivl;
  logic [TIME_W-1:0] fresh;
  logic [CNT_W-1:0]  ts_inc;
  logic [CNT_W-1:0]  ss_inc;
  logic              online_mid;
  logic              timed_out;
  logic              stale;
  cmd_t              c;

  assign pop = head_valid && (!out_valid || !out_stall);
  assign c   = head_cmd;

  always_comb begin
    poll_enabled_next       = poll_enabled;
    link_online_next        = link_online;
    awaiting_reply_next     = awaiting_reply;
    next_probe_time_next    = next_probe_time;
    next_pull_time_next     = next_pull_time;
    last_reply_time_next    = last_reply_time;
    last_probe_time_next    = last_probe_time;
    last_activity_time_next = last_activity_time;
    send_fail_count_next    = send_fail_count;
    backoff_end_time_next   = backoff_end_time;
    timeout_streak_next     = timeout_streak;
    stale_streak_next       = stale_streak;
    next_request_id_next    = next_request_id;
    res_next                = '0;

    in_backoff   = (backoff_end_time != '0) && !time_reached(c.now, backoff_end_time);
    probe_due    = !in_backoff && time_reached(c.now, next_probe_time);
    pull_due     = !in_backoff && !probe_due && time_reached(c.now, next_pull_time);
    fail_inc     = sat_inc(send_fail_count);
    now_plus_bo  = c.now + TIME_W'(backoff_ms(fail_inc));
    now_plus_ivl = c.now + TIME_W'(cfg.interval);
    fresh        = (last_activity_time != '0) ? last_activity_time : last_reply_time;
    ts_inc       = sat_inc(timeout_streak);
    ss_inc       = sat_inc(stale_streak);
    // an accepted probe restarts the reply clock, so it cannot time out now
    timed_out    = awaiting_reply && !(probe_due && c.accept) &&
                   ((c.now - last_probe_time) > TIME_W'(cfg.reply_window));
    stale        = (fresh != '0) && ((c.now - fresh) > TIME_W'(cfg.stale_window));
    online_mid   = link_online;

    case (c.op)
      OP_TICK: begin
        if (poll_enabled) begin
          if (probe_due) begin
            res_next.kind        = REQ_PROBE;
            res_next.id          = next_request_id;
            next_request_id_next = next_request_id + 1'b1;
            if (c.accept) begin
              res_next.sent         = 1'b1;
              awaiting_reply_next   = 1'b1;
              last_probe_time_next  = c.now;
              next_probe_time_next  = now_plus_ivl;
              send_fail_count_next  = '0;
              backoff_end_time_next = '0;
            end else begin
              send_fail_count_next  = fail_inc;
              backoff_end_time_next = now_plus_bo;
              next_probe_time_next  = now_plus_bo;
            end
          end else if (pull_due) begin
            if (!link_online) begin
              next_pull_time_next = now_plus_ivl;
            end else begin
              res_next.kind        = REQ_PULL;
              res_next.id          = next_request_id;
              next_request_id_next = next_request_id + 1'b1;
              if (c.accept) begin
                res_next.sent         = 1'b1;
                send_fail_count_next  = '0;
                backoff_end_time_next = '0;
                next_pull_time_next   = now_plus_ivl;
              end else begin
                send_fail_count_next  = fail_inc;
                backoff_end_time_next = now_plus_bo;
                next_pull_time_next   = now_plus_bo;
              end
            end
          end

          if (timed_out) begin
            awaiting_reply_next = 1'b0;
            timeout_streak_next = ts_inc;
            if (ts_inc >= cfg.to_limit && link_online) begin
              online_mid      = 1'b0;
              res_next.off_to = 1'b1;
            end
          end

          if (stale) begin
            stale_streak_next = ss_inc;
            if (ss_inc >= cfg.st_limit && online_mid) begin
              res_next.off_st = 1'b1;
            end
          end else begin
            stale_streak_next = '0;
          end
          link_online_next = online_mid && !res_next.off_st;
        end
      end
      OP_HEARD: begin
        res_next.rec            = !link_online && c.flag;
        link_online_next        = c.flag;
        last_reply_time_next    = c.now;
        last_activity_time_next = c.now;
        awaiting_reply_next     = 1'b0;
        timeout_streak_next     = '0;
        stale_streak_next       = '0;
        send_fail_count_next    = '0;
        backoff_end_time_next   = '0;
      end
      OP_ENABLE: begin
        poll_enabled_next       = c.flag;
        next_probe_time_next    = c.now;
        next_pull_time_next     = c.now + TIME_W'(cfg.interval >> 1);
        awaiting_reply_next     = 1'b0;
        last_activity_time_next = '0;
        timeout_streak_next     = '0;
        stale_streak_next       = '0;
        send_fail_count_next    = '0;
        backoff_end_time_next   = '0;
      end
      OP_CLEAR: begin
        link_online_next        = 1'b0;
        awaiting_reply_next     = 1'b0;
        last_reply_time_next    = '0;
        last_probe_time_next    = '0;
        last_activity_time_next = '0;
        send_fail_count_next    = '0;
        backoff_end_time_next   = '0;
        timeout_streak_next     = '0;
        stale_streak_next       = '0;
      end
      default: begin
      end
    endcase

    res_next.online = link_online_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_enabled       <= 1'b0;
      link_online        <= 1'b0;
      awaiting_reply     <= 1'b0;
      next_probe_time    <= '0;
      next_pull_time     <= '0;
      last_reply_time    <= '0;
      last_probe_time    <= '0;
      last_activity_time <= '0;
      send_fail_count    <= '0;
      backoff_end_time   <= '0;
      timeout_streak     <= '0;
      stale_streak       <= '0;
      next_request_id    <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (pop) begin
        poll_enabled       <= poll_enabled_next;
        link_online        <= link_online_next;
        awaiting_reply     <= awaiting_reply_next;
        next_probe_time    <= next_probe_time_next;
        next_pull_time     <= next_pull_time_next;
        last_reply_time    <= last_reply_time_next;
        last_probe_time    <= last_probe_time_next;
        last_activity_time <= last_activity_time_next;
        send_fail_count    <= send_fail_count_next;
        backoff_end_time   <= backoff_end_time_next;
        timeout_streak     <= timeout_streak_next;
        stale_streak       <= stale_streak_next;
        next_request_id    <= next_request_id_next;
        out_valid          <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

endmodule

@@ hw/rtl/link_liveness_poll_scheduler.sv @@
// Link liveness supervisor: takes one timestamped event per beat (poll tick,
// liveness reply, peer activity, enable, link reset) and returns exactly one
// result beat per event with the request issued and any online/offline change.
// Sustained rate is one event per clock on both sides while out_stall is low;
// every event is resolved by the back-end state unit, which holds all link
// state. With no stalls an event passes the input register, the two-entry
// command queue and the result register in turn; with the output stalled, up
// to four events are held inside (input register, two queue entries, result
// register) before in_stall rises. Registers sit at byte
// addresses 0 (poll interval, writes below 300 are dropped), 4 (timeout miss
// limit) and 8 (stale miss limit); write them only while no event is in flight.
module link_liveness_poll_scheduler
  import llps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              poll_permit,
  input  logic              tx_accept,
  input  logic              reply_online,
  input  logic              enable_flag,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] request_kind,
  output logic              request_sent,
  output logic [TIME_W-1:0] request_id,
  output logic              offline_by_timeout,
  output logic              offline_by_stale,
  output logic              recovered,
  output logic              peer_online
);

  cfg_t cfg;
  logic cfg_wr;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;
  res_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval     <= IVL_W'(INTERVAL_RESET);
      cfg.reply_window <= reply_window_of(IVL_W'(INTERVAL_RESET));
      cfg.stale_window <= stale_window_of(IVL_W'(INTERVAL_RESET));
      cfg.to_limit     <= CNT_W'(LIMIT_RESET);
      cfg.st_limit     <= CNT_W'(LIMIT_RESET);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INTERVAL: begin
          if (pwdata[IVL_W-1:0] >= IVL_W'(MIN_INTERVAL_MS)) begin
            cfg.interval     <= pwdata[IVL_W-1:0];
            cfg.reply_window <= reply_window_of(pwdata[IVL_W-1:0]);
            cfg.stale_window <= stale_window_of(pwdata[IVL_W-1:0]);
          end
        end
        REG_TO_LIMIT: cfg.to_limit <= pwdata[CNT_W-1:0];
        REG_ST_LIMIT: cfg.st_limit <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INTERVAL: prdata = DATA_W'(cfg.interval);
      REG_TO_LIMIT: prdata = DATA_W'(cfg.to_limit);
      REG_ST_LIMIT: prdata = DATA_W'(cfg.st_limit);
      default:      prdata = '0;
    endcase
  end

  llps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .now_ms       (now_ms),
    .poll_permit  (poll_permit),
    .tx_accept    (tx_accept),
    .reply_online (reply_online),
    .enable_flag  (enable_flag),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  llps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  llps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign request_kind       = res.kind;
  assign request_sent       = res.sent;
  assign request_id         = res.id;
  assign offline_by_timeout = res.off_to;
  assign offline_by_stale   = res.off_st;
  assign recovered          = res.rec;
  assign peer_online        = res.online;

endmodule

@@ hw/rtl/llps_checker.sv @@
module llps_checker
  import llps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [KIND_W-1:0] request_kind,
  input logic              request_sent,
  input logic [TIME_W-1:0] request_id,
  input logic              offline_by_timeout,
  input logic              offline_by_stale,
  input logic              recovered,
  input logic              peer_online
);

  // a stalled result beat must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(request_id) &&
      $stable(request_kind) && $stable(peer_online))
    else $error("result beat changed while stalled");

  a_no_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_kind == REQ_NONE |-> !request_sent && request_id == '0)
    else $error("send flag or id without a request");

  a_offline: assert property (@(posedge clk) disable iff (rst)
    out_valid && (offline_by_timeout || offline_by_stale) |->
      !peer_online && !recovered && !(offline_by_timeout && offline_by_stale))
    else $error("inconsistent offline report");

  a_recover: assert property (@(posedge clk) disable iff (rst)
    out_valid && recovered |-> peer_online && request_kind == REQ_NONE)
    else $error("recovery reported while offline or with a request");

endmodule

bind link_liveness_poll_scheduler llps_checker u_llps_checker (.*);
